@@ rtl/ougs_pkg.sv @@
// Shared types, codes and constants of the upstream grant scheduler.
`timescale 1ns / 1ps
`default_nettype none
package ougs_pkg;

	localparam int unsigned LEN_W   = 16;
	localparam int unsigned GRANT_W = 24;
	localparam int unsigned CAP_W   = 28;
	localparam int unsigned OVH_W   = 8;
	localparam int unsigned FRAG_W  = 8;

	localparam int unsigned QUEUE_DEPTH_DEF = 256;

	localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(100000000);
	// Header overhead: 3 + 1 + 1 + 5 + 8 bytes.
	localparam logic [OVH_W-1:0]  OVH_RESET = OVH_W'(3 + 1 + 1 + 5 + 8);
	localparam logic [FRAG_W-1:0] FRAG_MAX  = '1;

	typedef enum logic [1:0] {
		CMD_ENQUEUE = 2'd0,
		CMD_GRANT   = 2'd1,
		CMD_SEND    = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_ADMIT  = 2'd0,
		KIND_REPORT = 2'd1,
		KIND_SENT   = 2'd2,
		KIND_IDLE   = 2'd3
	} kind_t;

	typedef enum logic {
		CFG_BUFFER_CAPACITY = 1'b0,
		CFG_HEADER_OVERHEAD = 1'b1
	} cfg_index_t;

	// One FIFO entry: remaining length and fragment count of a packet.
	typedef struct packed {
		logic [FRAG_W-1:0] frag;
		logic [LEN_W-1:0]  len;
	} entry_t;

	// Per-cycle control from the scheduler to one container.
	typedef struct packed {
		logic               push;
		logic [LEN_W-1:0]   push_len;
		logic               serve;
		logic               load;
		logic [GRANT_W-1:0] load_grant;
	} ctl_t;

	// Container status and the outcome a serve would have this cycle.
	typedef struct packed {
		logic               eligible;
		logic               full;
		logic [CAP_W-1:0]   pending;
		logic [LEN_W-1:0]   moved;
		logic               whole;
		logic [FRAG_W-1:0]  frag;
	} stat_t;

endpackage
`default_nettype wire

@@ rtl/ougs_container.sv @@
// One traffic container: packet FIFO with cached head, byte counters and grant.
`timescale 1ns / 1ps
`default_nettype none
module ougs_container #(
	parameter int unsigned QUEUE_DEPTH = ougs_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire ougs_pkg::ctl_t ctl,
	output ougs_pkg::stat_t     stat
);
	import ougs_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

	entry_t             mem_q [QUEUE_DEPTH];
	entry_t             head_rd_q;
	entry_t             head_hold_q;
	logic               head_sel_q;
	logic [PTR_W-1:0]   head_ptr_q;
	logic [PTR_W-1:0]   tail_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic [CAP_W-1:0]   pending_q;
	logic [GRANT_W-1:0] grant_q;

	entry_t             head;
	logic               fits;
	logic               pop;
	logic [LEN_W-1:0]   moved;
	logic [FRAG_W-1:0]  frag_next;
	logic [PTR_W-1:0]   head_ptr_next;
	logic [PTR_W-1:0]   tail_ptr_next;

	// The head entry lives either in the read register (just popped in) or in
	// the hold register (freshly enqueued into an empty FIFO, or shrunk).
	assign head          = head_sel_q ? head_rd_q : head_hold_q;
	assign fits          = {{(GRANT_W - LEN_W){1'b0}}, head.len} <= grant_q;
	assign moved         = fits ? head.len : grant_q[LEN_W-1:0];
	assign frag_next     = (!fits && head.frag != FRAG_MAX) ? head.frag + 1'b1 : head.frag;
	assign pop           = ctl.serve && fits;
	assign head_ptr_next = (head_ptr_q == LAST_PTR) ? '0 : head_ptr_q + 1'b1;
	assign tail_ptr_next = (tail_ptr_q == LAST_PTR) ? '0 : tail_ptr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem_q[tail_ptr_q] <= '{frag: '0, len: ctl.push_len};
		end
		if (pop) begin
			head_rd_q <= mem_q[head_ptr_next];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push && count_q == '0) begin
			head_hold_q <= '{frag: '0, len: ctl.push_len};
		end else if (ctl.serve && !fits) begin
			head_hold_q <= '{frag: frag_next, len: head.len - moved};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_sel_q <= 1'b0;
			head_ptr_q <= '0;
			tail_ptr_q <= '0;
			count_q    <= '0;
			pending_q  <= '0;
			grant_q    <= '0;
		end else begin
			if (ctl.push) begin
				tail_ptr_q <= tail_ptr_next;
				count_q    <= count_q + 1'b1;
				pending_q  <= pending_q + {{(CAP_W - LEN_W){1'b0}}, ctl.push_len};
				if (count_q == '0) begin
					head_sel_q <= 1'b0;
				end
			end
			if (ctl.serve) begin
				pending_q <= (pending_q > {{(CAP_W - LEN_W){1'b0}}, moved})
					? pending_q - {{(CAP_W - LEN_W){1'b0}}, moved} : '0;
				if (fits) begin
					grant_q    <= grant_q - {{(GRANT_W - LEN_W){1'b0}}, head.len};
					head_ptr_q <= head_ptr_next;
					count_q    <= count_q - 1'b1;
					head_sel_q <= 1'b1;
				end else begin
					grant_q    <= '0;
					head_sel_q <= 1'b0;
				end
			end
			if (ctl.load) begin
				grant_q <= ctl.load_grant;
			end
		end
	end

	assign stat.eligible = (grant_q != '0) && (pending_q != '0) && (count_q != '0);
	assign stat.full     = (count_q == DEPTH_CNT);
	assign stat.pending  = pending_q;
	assign stat.moved    = moved;
	assign stat.whole    = fits;
	assign stat.frag     = frag_next;

endmodule
`default_nettype wire

@@ rtl/onu_upstream_grant_scheduler_core.sv @@
// Top level of the upstream grant scheduler: command decode and result register.
`timescale 1ns / 1ps
`default_nettype none
// Upstream scheduler for two traffic containers (priority and background)
// that share one byte budget.
// Commands come in on start; a transfer takes place at a rising edge with
// start high and busy low. Busy never rises, so one command can be given in
// every cycle. A command is captured in the input register, executed in the
// next cycle by a single pass through the container logic, and its result is
// loaded into the result register while done pulses for exactly one cycle,
// one result per command. The occupancy ports show the pending bytes of
// both containers after the command. Throughput is one command per cycle;
// each FIFO keeps its head entry in a register and prefetches the next
// entry on a pop, so a send never waits on the FIFO memory read.
// The receiver cannot stall: each result is valid only in its done cycle.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once.
// The user gives them with no command in flight; the block does not enforce it.
// Reset empties both FIFOs and clears all byte counts and grants; the FIFO
// memories themselves are not cleared, and no clearing pass is needed.
module onu_upstream_grant_scheduler_core #(
	parameter int unsigned QUEUE_DEPTH = ougs_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic                         cfg_index,
	input  wire logic [ougs_pkg::CAP_W-1:0]   cfg_wdata,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [1:0]                   cmd,
	input  wire logic                         traffic_class,
	input  wire logic [ougs_pkg::LEN_W-1:0]   packet_length,
	input  wire logic [ougs_pkg::GRANT_W-1:0] grant_priority_in,
	input  wire logic [ougs_pkg::GRANT_W-1:0] grant_background_in,
	output logic                              done,
	output logic [1:0]                        kind,
	output logic                              accepted,
	output logic                              sent_class,
	output logic [ougs_pkg::LEN_W-1:0]        sent_length,
	output logic [ougs_pkg::FRAG_W-1:0]       fragment_number,
	output logic                              whole_remainder,
	output logic [ougs_pkg::CAP_W-1:0]        occupancy_priority,
	output logic [ougs_pkg::CAP_W-1:0]        occupancy_background
);
	import ougs_pkg::*;

	// Configuration registers.
	logic [CAP_W-1:0]   cap_q;
	logic [OVH_W-1:0]   ovh_q;

	// Input register.
	logic               valid_s1;
	logic [1:0]         cmd_s1;
	logic               cls_s1;
	logic [LEN_W-1:0]   len_s1;
	logic [GRANT_W-1:0] gp_s1;
	logic [GRANT_W-1:0] gb_s1;

	// Result register.
	logic               done_s2;
	logic [1:0]         kind_s2;
	logic               accepted_s2;
	logic               class_s2;
	logic [LEN_W-1:0]   length_s2;
	logic [FRAG_W-1:0]  frag_s2;
	logic               whole_s2;

	ctl_t               ctl_pri;
	ctl_t               ctl_bkg;
	stat_t              st_pri;
	stat_t              st_bkg;

	logic               is_enq;
	logic               is_grant;
	logic               is_send;
	logic [CAP_W+1:0]   total;
	logic               admit;
	logic               serve_pri;
	logic               serve_bkg;
	logic [GRANT_W-1:0] grant_pri;
	logic [1:0]         kind_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
			ovh_q <= OVH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BUFFER_CAPACITY: cap_q <= cfg_wdata;
				CFG_HEADER_OVERHEAD: ovh_q <= cfg_wdata[OVH_W-1:0];
				default: ;
			endcase
		end
	end

	// Every command finishes in one pass, so the port never pushes back.
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_s2  <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			done_s2  <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= cmd;
			cls_s1 <= traffic_class;
			len_s1 <= packet_length;
			gp_s1  <= grant_priority_in;
			gb_s1  <= grant_background_in;
		end
	end

	assign is_enq   = valid_s1 && (cmd_s1 == CMD_ENQUEUE);
	assign is_grant = valid_s1 && (cmd_s1 == CMD_GRANT);
	assign is_send  = valid_s1 && (cmd_s1 == CMD_SEND);

	// Admission checks the shared byte budget and the target FIFO's room.
	assign total = {2'b00, st_pri.pending} + {2'b00, st_bkg.pending}
		+ {{(CAP_W + 2 - LEN_W){1'b0}}, len_s1};
	assign admit = (total <= {2'b00, cap_q})
		&& !(cls_s1 ? st_bkg.full : st_pri.full);

	// The priority container is served first whenever it can send anything.
	assign serve_pri = is_send && st_pri.eligible;
	assign serve_bkg = is_send && !st_pri.eligible && st_bkg.eligible;

	// Priority grant net of the header overhead, floored at zero.
	assign grant_pri = (gp_s1 > {{(GRANT_W - OVH_W){1'b0}}, ovh_q})
		? gp_s1 - {{(GRANT_W - OVH_W){1'b0}}, ovh_q} : '0;

	always_comb begin
		ctl_pri            = '0;
		ctl_pri.push       = is_enq && admit && !cls_s1;
		ctl_pri.push_len   = len_s1;
		ctl_pri.serve      = serve_pri;
		ctl_pri.load       = is_grant;
		ctl_pri.load_grant = grant_pri;
		ctl_bkg            = '0;
		ctl_bkg.push       = is_enq && admit && cls_s1;
		ctl_bkg.push_len   = len_s1;
		ctl_bkg.serve      = serve_bkg;
		ctl_bkg.load       = is_grant;
		ctl_bkg.load_grant = gb_s1;
	end

	ougs_container #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_pri (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl_pri),
		.stat  (st_pri)
	);

	ougs_container #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_bkg (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl_bkg),
		.stat  (st_bkg)
	);

	always_comb begin
		case (cmd_s1)
			CMD_ENQUEUE: kind_d = KIND_ADMIT;
			CMD_GRANT:   kind_d = KIND_REPORT;
			CMD_SEND:    kind_d = (serve_pri || serve_bkg) ? KIND_SENT : KIND_IDLE;
			default:     kind_d = KIND_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			kind_s2     <= kind_d;
			accepted_s2 <= is_enq && admit;
			class_s2    <= serve_bkg;
			length_s2   <= serve_pri ? st_pri.moved : (serve_bkg ? st_bkg.moved : '0);
			frag_s2     <= serve_pri ? st_pri.frag : (serve_bkg ? st_bkg.frag : '0);
			whole_s2    <= serve_pri ? st_pri.whole : (serve_bkg && st_bkg.whole);
		end
	end

	assign done            = done_s2;
	assign kind            = kind_s2;
	assign accepted        = accepted_s2;
	assign sent_class      = class_s2;
	assign sent_length     = length_s2;
	assign fragment_number = frag_s2;
	assign whole_remainder = whole_s2;

	// In the done cycle the byte counters hold the state just after the
	// command that produced the result.
	assign occupancy_priority   = st_pri.pending;
	assign occupancy_background = st_bkg.pending;

endmodule
`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench of the upstream grant scheduler core.
`timescale 1ns / 1ps
module tb;
	import ougs_pkg::*;

	// One command as it is offered on the command port.
	typedef struct {
		cmd_t               op;
		logic               cls;
		logic [LEN_W-1:0]   len;
		logic [GRANT_W-1:0] gp;
		logic [GRANT_W-1:0] gb;
	} sched_item_t;

	// One result as it appears on the result ports in a done cycle.
	typedef struct {
		kind_t              kind;
		logic               accepted;
		logic               sent_class;
		logic [LEN_W-1:0]   sent_length;
		logic [FRAG_W-1:0]  fragment;
		logic               whole;
		logic [CAP_W-1:0]   occ_pri;
		logic [CAP_W-1:0]   occ_bg;
	} sched_result_t;

	// A row of the directed table. When typed is set, the result was read off
	// the specification by hand and is checked as written; otherwise the
	// scheduler model below supplies it.
	typedef struct {
		sched_item_t   item;
		bit            typed;
		sched_result_t res;
	} stim_row_t;

	localparam int DIR_ROWS    = 24;
	localparam int MAX_REPORTS = 40;
	localparam int QD          = QUEUE_DEPTH_DEF;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic                cfg_index = 1'b0;
	logic [CAP_W-1:0]    cfg_wdata = '0;
	logic                start = 1'b0;
	logic                busy;
	logic [1:0]          cmd = '0;
	logic                traffic_class = 1'b0;
	logic [LEN_W-1:0]    packet_length = '0;
	logic [GRANT_W-1:0]  grant_priority_in = '0;
	logic [GRANT_W-1:0]  grant_background_in = '0;
	logic                done;
	logic [1:0]          kind;
	logic                accepted;
	logic                sent_class;
	logic [LEN_W-1:0]    sent_length;
	logic [FRAG_W-1:0]   fragment_number;
	logic                whole_remainder;
	logic [CAP_W-1:0]    occupancy_priority;
	logic [CAP_W-1:0]    occupancy_background;

	onu_upstream_grant_scheduler_core i_dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_we               (cfg_we),
		.cfg_index            (cfg_index),
		.cfg_wdata            (cfg_wdata),
		.start                (start),
		.busy                 (busy),
		.cmd                  (cmd),
		.traffic_class        (traffic_class),
		.packet_length        (packet_length),
		.grant_priority_in    (grant_priority_in),
		.grant_background_in  (grant_background_in),
		.done                 (done),
		.kind                 (kind),
		.accepted             (accepted),
		.sent_class           (sent_class),
		.sent_length          (sent_length),
		.fragment_number      (fragment_number),
		.whole_remainder      (whole_remainder),
		.occupancy_priority   (occupancy_priority),
		.occupancy_background (occupancy_background)
	);

	// 20 ns clock period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Scheduler model state. Index 0 is the priority container, index 1 the
	// background one. Each FIFO is a circular store with a head pointer and
	// a fill count, just as the hardware keeps it.
	entry_t             slot_mem [2][QD];
	int                 fifo_head [2] = '{0, 0};
	int                 fifo_count [2] = '{0, 0};
	logic [CAP_W-1:0]   pend_bytes [2] = '{'0, '0};
	logic [GRANT_W-1:0] grant_bytes [2] = '{'0, '0};
	logic [CAP_W-1:0]   cap_cfg = CAP_RESET;
	logic [OVH_W-1:0]   ovh_cfg = OVH_RESET;

	sched_result_t due_results [$];
	sched_result_t blank_result;
	stim_row_t     dir_tab [DIR_ROWS];
	int            errors = 0;
	int            burst_left = 0;

	// A container is served only with a grant, pending bytes and a queued
	// packet all present.
	function automatic bit can_serve(int c);
		return grant_bytes[c] != '0 && pend_bytes[c] != '0 && fifo_count[c] != 0;
	endfunction

	// Advances the scheduler model by one command and returns its result.
	function automatic sched_result_t schedule_step(sched_item_t it);
		sched_result_t r;
		logic [CAP_W+1:0] total;
		entry_t head;
		logic [LEN_W-1:0] moved;
		int c;
		r = '{KIND_IDLE, 1'b0, 1'b0, '0, '0, 1'b0, '0, '0};
		case (it.op)
			CMD_ENQUEUE: begin
				r.kind = KIND_ADMIT;
				total = (CAP_W+2)'(pend_bytes[0]) + (CAP_W+2)'(pend_bytes[1])
					+ (CAP_W+2)'(it.len);
				// Admission needs room in bytes over both containers and a free
				// FIFO slot; a full FIFO drops the packet even if the bytes fit.
				if (total <= (CAP_W+2)'(cap_cfg) && fifo_count[it.cls] < QD) begin
					slot_mem[it.cls][(fifo_head[it.cls] + fifo_count[it.cls]) % QD] =
						'{frag: '0, len: it.len};
					fifo_count[it.cls]++;
					pend_bytes[it.cls] = pend_bytes[it.cls] + CAP_W'(it.len);
					r.accepted = 1'b1;
				end
			end
			CMD_GRANT: begin
				r.kind = KIND_REPORT;
				// The header overhead comes off the priority grant, floored at zero.
				grant_bytes[0] = (it.gp > GRANT_W'(ovh_cfg)) ? it.gp - GRANT_W'(ovh_cfg) : '0;
				grant_bytes[1] = it.gb;
			end
			CMD_SEND: begin
				c = can_serve(0) ? 0 : (can_serve(1) ? 1 : -1);
				if (c >= 0) begin
					head = slot_mem[c][fifo_head[c]];
					if (GRANT_W'(head.len) <= grant_bytes[c]) begin
						// The rest of the head packet fits and leaves whole.
						moved = head.len;
						grant_bytes[c] = grant_bytes[c] - GRANT_W'(head.len);
						fifo_head[c] = (fifo_head[c] + 1) % QD;
						fifo_count[c]--;
						r.whole = 1'b1;
					end else begin
						// A fragment the size of the grant leaves and uses it up.
						moved = grant_bytes[c][LEN_W-1:0];
						if (head.frag != FRAG_MAX)
							head.frag++;
						head.len = head.len - moved;
						slot_mem[c][fifo_head[c]] = head;
						grant_bytes[c] = '0;
					end
					pend_bytes[c] = (pend_bytes[c] > CAP_W'(moved)) ?
						pend_bytes[c] - CAP_W'(moved) : '0;
					r.kind = KIND_SENT;
					r.sent_class = (c == 1);
					r.sent_length = moved;
					r.fragment = head.frag;
				end
			end
			default: ;
		endcase
		r.occ_pri = pend_bytes[0];
		r.occ_bg = pend_bytes[1];
		return r;
	endfunction

	// Random command with random content. Most lengths and grants are small,
	// so that packets get both sent whole and split, while a share spans the
	// full field so that every bit toggles and the byte limit is reached.
	function automatic sched_item_t rand_item();
		sched_item_t it;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			it.op = CMD_ENQUEUE;
		else if (pick < 60)
			it.op = CMD_GRANT;
		else if (pick < 95)
			it.op = CMD_SEND;
		else
			it.op = CMD_NONE;
		it.cls = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 9);
		if (pick == 0)
			it.len = '0;
		else if (pick < 3)
			it.len = LEN_W'($urandom);
		else
			it.len = LEN_W'($urandom_range(1, 1500));
		it.gp = ($urandom_range(0, 9) < 7) ? GRANT_W'($urandom_range(0, 3000))
			: GRANT_W'($urandom);
		it.gb = ($urandom_range(0, 9) < 7) ? GRANT_W'($urandom_range(0, 3000))
			: GRANT_W'($urandom);
		return it;
	endfunction

	// Offers one command and waits for its transfer. The sender works in
	// bursts: when a burst runs out, start may drop for a random gap before
	// the next one begins. About a quarter of the bursts follow on with no
	// gap at all. At each edge start gets at most one assignment.
	task automatic issue(sched_item_t it, bit typed, sched_result_t typed_res);
		int gap;
		sched_result_t want;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
			burst_left = $urandom_range(1, 24);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		start <= 1'b1;
		cmd <= it.op;
		traffic_class <= it.cls;
		packet_length <= it.len;
		grant_priority_in <= it.gp;
		grant_background_in <= it.gb;
		// Busy is read right after the edge, so it still holds the value that
		// the block saw at that edge.
		do
			@(posedge clk);
		while (busy);
		want = schedule_step(it);
		if (typed)
			want = typed_res;
		due_results.push_back(want);
		burst_left--;
	endtask

	task automatic run_mixed(int n);
		repeat (n) issue(rand_item(), 1'b0, blank_result);
	endtask

	// Stops offering commands and waits until every result has come back,
	// plus a little slack.
	task automatic settle();
		start <= 1'b0;
		burst_left = 0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Writes the capacity register, then the overhead register, on back-to-back edges. The write enable stays
	// high across the pair and drops once.
	task automatic configure(logic [CAP_W-1:0] cap, logic [OVH_W-1:0] ovh);
		cfg_we <= 1'b1;
		cfg_index <= CFG_BUFFER_CAPACITY;
		cfg_wdata <= cap;
		@(posedge clk);
		cap_cfg = cap;
		cfg_index <= CFG_HEADER_OVERHEAD;
		cfg_wdata <= CAP_W'(ovh);
		@(posedge clk);
		ovh_cfg = ovh;
		cfg_we <= 1'b0;
	endtask

	task automatic check_field(string name, logic [CAP_W-1:0] want, logic [CAP_W-1:0] got);
		if (got !== want) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// Result monitor. Every done cycle is one result transfer; it is matched
	// against the oldest expected result, field by field.
	always @(posedge clk) begin : result_check
		sched_result_t want;
		if (arst_n && done) begin
			if (due_results.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t ns: result transfer with none expected, expected none, actual kind %0d",
						$time, kind);
			end else begin
				want = due_results.pop_front();
				check_field("kind", CAP_W'(want.kind), CAP_W'(kind));
				check_field("accepted", CAP_W'(want.accepted), CAP_W'(accepted));
				check_field("sent_class", CAP_W'(want.sent_class), CAP_W'(sent_class));
				check_field("sent_length", CAP_W'(want.sent_length), CAP_W'(sent_length));
				check_field("fragment_number", CAP_W'(want.fragment), CAP_W'(fragment_number));
				check_field("whole_remainder", CAP_W'(want.whole), CAP_W'(whole_remainder));
				check_field("occupancy_priority", want.occ_pri, occupancy_priority);
				check_field("occupancy_background", want.occ_bg, occupancy_background);
			end
		end
	end

	initial begin
		sched_item_t it;
		int n;
		int extra;
		int spill;

		blank_result = '{KIND_IDLE, 1'b0, 1'b0, '0, '0, 1'b0, '0, '0};

		// Directed part, run with the register values that reset leaves.
		// It covers every command, the extremes of each field, a send on an
		// empty scheduler, a zero-length packet that cannot leave while its
		// container has no pending bytes, fragments and their remainders,
		// and priority grants below, at and above the header overhead.
		dir_tab = '{
			// Send on an empty scheduler finds nothing.
			'{'{CMD_SEND, 1'b0, 16'd0, 24'd0, 24'd0}, 1'b1,
				'{KIND_IDLE, 1'b0, 1'b0, 16'd0, 8'd0, 1'b0, 28'd0, 28'd0}},
			'{'{CMD_GRANT, 1'b0, 16'd0, 24'd0, 24'd0}, 1'b1,
				'{KIND_REPORT, 1'b0, 1'b0, 16'd0, 8'd0, 1'b0, 28'd0, 28'd0}},
			// The unused command changes nothing, even with every field at its top.
			'{'{CMD_NONE, 1'b1, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF}, 1'b1,
				'{KIND_IDLE, 1'b0, 1'b0, 16'd0, 8'd0, 1'b0, 28'd0, 28'd0}},
			'{'{CMD_ENQUEUE, 1'b0, 16'd0, 24'd0, 24'd0}, 1'b1,
				'{KIND_ADMIT, 1'b1, 1'b0, 16'd0, 8'd0, 1'b0, 28'd0, 28'd0}},
			'{'{CMD_GRANT, 1'b0, 16'd0, 24'hFFFFFF, 24'hFFFFFF}, 1'b1,
				'{KIND_REPORT, 1'b0, 1'b0, 16'd0, 8'd0, 1'b0, 28'd0, 28'd0}},
			// The zero-length packet is stuck: no pending bytes in its container.
			'{'{CMD_SEND, 1'b0, 16'd0, 24'd0, 24'd0}, 1'b1,
				'{KIND_IDLE, 1'b0, 1'b0, 16'd0, 8'd0, 1'b0, 28'd0, 28'd0}},
			'{'{CMD_ENQUEUE, 1'b0, 16'hFFFF, 24'd0, 24'd0}, 1'b1,
				'{KIND_ADMIT, 1'b1, 1'b0, 16'd0, 8'd0, 1'b0, 28'd65535, 28'd0}},
			// Now it leaves, carrying no bytes, ahead of the longest packet.
			'{'{CMD_SEND, 1'b1, 16'd0, 24'd0, 24'd0}, 1'b1,
				'{KIND_SENT, 1'b0, 1'b0, 16'd0, 8'd0, 1'b1, 28'd65535, 28'd0}},
			'{'{CMD_SEND, 1'b0, 16'd0, 24'd0, 24'd0}, 1'b1,
				'{KIND_SENT, 1'b0, 1'b0, 16'hFFFF, 8'd0, 1'b1, 28'd0, 28'd0}},
			'{'{CMD_ENQUEUE, 1'b1, 16'd1000, 24'd0, 24'd0}, 1'b0, blank_result},
			'{'{CMD_ENQUEUE, 1'b0, 16'd300, 24'd0, 24'd0}, 1'b0, blank_result},
			'{'{CMD_GRANT, 1'b0, 16'd0, 24'd118, 24'hFFFFFF}, 1'b0, blank_result},
			// A fragment of the priority head, then background gets its turn.
			'{'{CMD_SEND, 1'b0, 16'd0, 24'd0, 24'd0}, 1'b0, blank_result},
			'{'{CMD_SEND, 1'b0, 16'd0, 24'd0, 24'd0}, 1'b0, blank_result},
			// Priority grant below the overhead floors at zero.
			'{'{CMD_GRANT, 1'b1, 16'd0, 24'd17, 24'd0}, 1'b0, blank_result},
			'{'{CMD_SEND, 1'b0, 16'd0, 24'd0, 24'd0}, 1'b0, blank_result},
			'{'{CMD_ENQUEUE, 1'b1, 16'd80, 24'd0, 24'd0}, 1'b0, blank_result},
			// Priority grant exactly at the overhead.
			'{'{CMD_GRANT, 1'b0, 16'd0, 24'd18, 24'd50}, 1'b0, blank_result},
			'{'{CMD_SEND, 1'b0, 16'd0, 24'd0, 24'd0}, 1'b0, blank_result},
			'{'{CMD_SEND, 1'b0, 16'd0, 24'd0, 24'd0}, 1'b0, blank_result},
			'{'{CMD_GRANT, 1'b0, 16'd0, 24'd219, 24'd30}, 1'b0, blank_result},
			// Both remainders leave whole with their fragment counts.
			'{'{CMD_SEND, 1'b0, 16'd0, 24'd0, 24'd0}, 1'b0, blank_result},
			'{'{CMD_SEND, 1'b0, 16'd0, 24'd0, 24'd0}, 1'b0, blank_result},
			'{'{CMD_NONE, 1'b0, 16'h5A5A, 24'h123456, 24'hABCDEF}, 1'b0, blank_result}
		};

		// Reset is held from time zero and released at a rising edge.
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < DIR_ROWS; n++)
			issue(dir_tab[n].item, dir_tab[n].typed, dir_tab[n].res);

		// Random traffic with the reset register values.
		run_mixed(180);

		// A small byte limit makes drops on capacity common; no overhead.
		settle();
		configure(CAP_W'($urandom_range(2000, 20000)), '0);
		run_mixed(140);

		// Zero capacity admits only zero-length packets into an empty buffer;
		// the largest overhead.
		settle();
		configure('0, FRAG_MAX);
		run_mixed(40);

		// Largest capacity: fill one FIFO, then wear a single packet down to a
		// saturated fragment count.
		settle();
		configure('1, OVH_W'($urandom_range(1, 254)));

		// Empty the priority container with grants that fit any packet.
		while (fifo_count[0] != 0 && pend_bytes[0] != '0) begin
			if (grant_bytes[0] < GRANT_W'(65536)) begin
				it = rand_item();
				it.op = CMD_GRANT;
				it.gp = '1;
				issue(it, 1'b0, blank_result);
			end
			it = rand_item();
			it.op = CMD_SEND;
			issue(it, 1'b0, blank_result);
		end

		// Fill the background FIFO and offer a few more packets; those are
		// dropped for lack of a slot although the bytes would fit.
		spill = 0;
		while (spill < 4) begin
			if (fifo_count[1] == QD)
				spill++;
			it = rand_item();
			it.op = CMD_ENQUEUE;
			it.cls = 1'b1;
			it.len = LEN_W'($urandom);
			issue(it, 1'b0, blank_result);
		end

		// One long priority packet goes out in small fragments, one per grant,
		// until its fragment count has sat at the ceiling for a while.
		it = rand_item();
		it.op = CMD_ENQUEUE;
		it.cls = 1'b0;
		it.len = '1;
		issue(it, 1'b0, blank_result);
		extra = 0;
		for (n = 0; n < 400 && extra < 4; n++) begin
			it = rand_item();
			it.op = CMD_GRANT;
			it.gp = GRANT_W'(ovh_cfg) + GRANT_W'($urandom_range(1, 100));
			it.gb = '0;
			issue(it, 1'b0, blank_result);
			it = rand_item();
			it.op = CMD_SEND;
			issue(it, 1'b0, blank_result);
			// Occasional noise that leaves the grants alone.
			if ($urandom_range(0, 9) == 0) begin
				it = rand_item();
				if (it.op == CMD_GRANT || it.op == CMD_SEND)
					it.op = CMD_NONE;
				issue(it, 1'b0, blank_result);
			end
			if (fifo_count[0] != 0 && slot_mem[0][fifo_head[0]].frag == FRAG_MAX)
				extra++;
		end

		// A last random setting of both registers.
		settle();
		configure(CAP_W'($urandom_range(50000000, 268435455)), OVH_W'($urandom));
		run_mixed(160);

		settle();
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog: a correct run ends far sooner than this.
	initial begin
		#10ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/ougs_pkg.sv
rtl/ougs_container.sv
rtl/onu_upstream_grant_scheduler_core.sv
test/tb.sv
